// ===== rtl/complex_fixed_point_alu_top_defines.svh =====
// Assertion macros for the checker file.
`ifndef COMPLEX_FIXED_POINT_ALU_TOP_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cfa_pkg.sv =====
package cfa_pkg;

  // Default number of fraction bits of every Q part
  localparam int unsigned FRAC_BITS_DEF = 16;
  // Quotient bits resolved by the divider (one per stage)
  localparam int unsigned QB = 33;
  // Width of the divisor |b|^2 and of an operand magnitude
  localparam int unsigned ZW = 64;
  // Width of the partial remainder
  localparam int unsigned RW = ZW + QB;
  // Cycles from the accepting edge to the edge that takes the result
  localparam int unsigned LAT = QB + 5;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // One item as it travels through the divider stages
  typedef struct packed {
    op_t           op;
    logic          dz;
    logic [ZW-1:0] z;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [31:0]   pre_re;
    logic [31:0]   pre_im;
    logic          pre_ovf;
  } item_t;

  // Saturate a full-width signed value to 32 bits
  function automatic sat_t sat66(input logic signed [65:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
      s.val = 32'h7FFF_FFFF;
      s.ovf = 1'b1;
    end else if (v < -66'sh0_0000_0000_8000_0000) begin
      s.val = 32'h8000_0000;
      s.ovf = 1'b1;
    end
    return s;
  endfunction

  // Apply sign and saturation to an unsigned quotient
  function automatic sat_t pack_q(input logic neg, input logic big, input logic [QB-1:0] q);
    sat_t        s;
    logic [QB-1:0] lim;
    lim   = neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
    s.ovf = 1'b0;
    s.val = neg ? (32'd0 - q[31:0]) : q[31:0];
    if (big || q > lim) begin
      s.ovf = 1'b1;
      s.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s;
  endfunction

endpackage

// ===== rtl/complex_fixed_point_alu_top.sv =====
// Complex add, subtract, multiply and divide on signed Q parts.
// Output: the result strobe is high for one cycle for each accepted beat.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Datapath: six 32x32 multipliers, then a 33-stage restoring divider, one bit each.
// Reset: synchronous active-low rst_n clears every valid bit; payload is not reset.
module complex_fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS = cfa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_a_real,
  input  logic [31:0] in_a_imag,
  input  logic [31:0] in_b_real,
  input  logic [31:0] in_b_imag,
  output logic        out_valid,
  output logic [31:0] out_c_real,
  output logic [31:0] out_c_imag,
  output logic        out_divide_by_zero,
  output logic        out_overflow
);
  import cfa_pkg::*;

  logic accept;

  // stage 1
  logic               s1_v_r;
  op_t                s1_op_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [32:0] s1_sr_r, s1_si_r;
  logic signed [32:0] sr_nxt, si_nxt;

  // stage 2
  logic               s2_v_r;
  op_t                s2_op_r;
  logic signed [65:0] s2_vre_r, s2_vim_r;
  logic [ZW-1:0]      s2_z_r;
  logic signed [32:0] s2_sr_r, s2_si_r;
  logic signed [65:0] e_rr, e_ii, e_ri, e_ir;
  logic signed [65:0] vre_nxt, vim_nxt;

  // stage 3
  logic               s3_v_r;
  item_t              s3_r;
  item_t              s3_nxt;
  logic [65:0]        mag_re, mag_im;
  logic signed [65:0] sh_re, sh_im;
  sat_t               sat_re, sat_im;

  // stage 4 and divider chain
  logic               stg_v [0:QB];
  item_t              stg_item [0:QB];
  item_t              s4_nxt;

  // output
  logic               o_v_r;
  logic [31:0]        o_re_r, o_im_r;
  logic               o_dz_r, o_ovf_r;
  sat_t               q_re, q_im;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Form the partial products and the plain sums
  always_comb begin
    if (op_t'(in_op) == OP_SUB) begin
      sr_nxt = $signed({in_a_real[31], in_a_real}) - $signed({in_b_real[31], in_b_real});
      si_nxt = $signed({in_a_imag[31], in_a_imag}) - $signed({in_b_imag[31], in_b_imag});
    end else begin
      sr_nxt = $signed({in_a_real[31], in_a_real}) + $signed({in_b_real[31], in_b_real});
      si_nxt = $signed({in_a_imag[31], in_a_imag}) + $signed({in_b_imag[31], in_b_imag});
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= op_t'(in_op);
    p_rr_r  <= $signed(in_a_real) * $signed(in_b_real);
    p_ii_r  <= $signed(in_a_imag) * $signed(in_b_imag);
    p_ri_r  <= $signed(in_a_real) * $signed(in_b_imag);
    p_ir_r  <= $signed(in_a_imag) * $signed(in_b_real);
    p_bb_r  <= $signed(in_b_real) * $signed(in_b_real);
    p_cc_r  <= $signed(in_b_imag) * $signed(in_b_imag);
    s1_sr_r <= sr_nxt;
    s1_si_r <= si_nxt;
  end

  // Combine the products at full width
  always_comb begin
    e_rr = 66'(p_rr_r);
    e_ii = 66'(p_ii_r);
    e_ri = 66'(p_ri_r);
    e_ir = 66'(p_ir_r);
    if (s1_op_r == OP_MUL) begin
      vre_nxt = e_rr - e_ii;
      vim_nxt = e_ri + e_ir;
    end else begin
      vre_nxt = e_rr + e_ii;
      vim_nxt = e_ir - e_ri;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r  <= s1_op_r;
    s2_vre_r <= vre_nxt;
    s2_vim_r <= vim_nxt;
    s2_z_r   <= ZW'(p_bb_r) + ZW'(p_cc_r);
    s2_sr_r  <= s1_sr_r;
    s2_si_r  <= s1_si_r;
  end

  // Split sign and magnitude, finish add, subtract and multiply
  always_comb begin
    mag_re = s2_vre_r[65] ? 66'(-s2_vre_r) : 66'(s2_vre_r);
    mag_im = s2_vim_r[65] ? 66'(-s2_vim_r) : 66'(s2_vim_r);
    sh_re  = s2_vre_r >>> FRAC_BITS;
    sh_im  = s2_vim_r >>> FRAC_BITS;
    if (s2_op_r == OP_MUL) begin
      sat_re = sat66(sh_re);
      sat_im = sat66(sh_im);
    end else begin
      sat_re = sat66(66'(s2_sr_r));
      sat_im = sat66(66'(s2_si_r));
    end
    s3_nxt         = '0;
    s3_nxt.op      = s2_op_r;
    s3_nxt.dz      = (s2_z_r == '0);
    s3_nxt.z       = s2_z_r;
    s3_nxt.neg_re  = s2_vre_r[65];
    s3_nxt.neg_im  = s2_vim_r[65];
    s3_nxt.rem_re  = RW'(mag_re[ZW-1:0]) << FRAC_BITS;
    s3_nxt.rem_im  = RW'(mag_im[ZW-1:0]) << FRAC_BITS;
    s3_nxt.pre_re  = sat_re.val;
    s3_nxt.pre_im  = sat_im.val;
    s3_nxt.pre_ovf = sat_re.ovf | sat_im.ovf;
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
  end

  // Flag quotients that reach past the divider's range
  always_comb begin
    s4_nxt        = s3_r;
    s4_nxt.big_re = {1'b0, s3_r.rem_re} >= ((RW+1)'(s3_r.z) << QB);
    s4_nxt.big_im = {1'b0, s3_r.rem_im} >= ((RW+1)'(s3_r.z) << QB);
  end

  always_ff @(posedge clk) begin
    stg_item[0] <= s4_nxt;
  end

  // Advance the valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      stg_v[0] <= 1'b0;
    end else begin
      s1_v_r   <= accept;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      stg_v[0] <= s3_v_r;
    end
  end

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < QB; k++) begin : g_div
    cfa_div_stage #(
      .SHIFT(QB - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stg_v[k]),
      .in_item  (stg_item[k]),
      .out_valid(stg_v[k+1]),
      .out_item (stg_item[k+1])
    );
  end

  // Choose and saturate the final beat
  always_comb begin
    q_re = pack_q(stg_item[QB].neg_re, stg_item[QB].big_re, stg_item[QB].q_re);
    q_im = pack_q(stg_item[QB].neg_im, stg_item[QB].big_im, stg_item[QB].q_im);
  end

  always_ff @(posedge clk) begin
    if (stg_item[QB].op != OP_DIV) begin
      o_re_r  <= stg_item[QB].pre_re;
      o_im_r  <= stg_item[QB].pre_im;
      o_dz_r  <= 1'b0;
      o_ovf_r <= stg_item[QB].pre_ovf;
    end else if (stg_item[QB].dz) begin
      o_re_r  <= '0;
      o_im_r  <= '0;
      o_dz_r  <= 1'b1;
      o_ovf_r <= 1'b0;
    end else begin
      o_re_r  <= q_re.val;
      o_im_r  <= q_im.val;
      o_dz_r  <= 1'b0;
      o_ovf_r <= q_re.ovf | q_im.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= stg_v[QB];
    end
  end

  assign out_valid          = o_v_r;
  assign out_c_real         = o_re_r;
  assign out_c_imag         = o_im_r;
  assign out_divide_by_zero = o_dz_r;
  assign out_overflow       = o_ovf_r;

endmodule

// ===== rtl/cfa_div_stage.sv =====
module cfa_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  cfa_pkg::item_t in_item,
  output logic          out_valid,
  output cfa_pkg::item_t out_item
);
  import cfa_pkg::*;

  logic          v_r;
  item_t         item_r;
  item_t         item_nxt;
  logic [RW-1:0] zs;

  // Resolve one quotient bit of each part
  always_comb begin
    zs       = RW'(in_item.z) << SHIFT;
    item_nxt = in_item;
    if (in_item.rem_re >= zs) begin
      item_nxt.rem_re      = in_item.rem_re - zs;
      item_nxt.q_re[SHIFT] = 1'b1;
    end
    if (in_item.rem_im >= zs) begin
      item_nxt.rem_im      = in_item.rem_im - zs;
      item_nxt.q_im[SHIFT] = 1'b1;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

// ===== rtl/cfa_checker.sv =====
`include "complex_fixed_point_alu_top_defines.svh"

module cfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_op,
  input logic [31:0] in_a_real,
  input logic [31:0] in_a_imag,
  input logic [31:0] in_b_real,
  input logic [31:0] in_b_imag,
  input logic        out_valid,
  input logic [31:0] out_c_real,
  input logic [31:0] out_c_imag,
  input logic        out_divide_by_zero,
  input logic        out_overflow
);
  import cfa_pkg::*;

  // A result beat follows an accepted beat after the fixed latency
  `CFA_ASSERT_SAME(a_no_phantom, out_valid, $past(start && !busy, LAT), "result without input")

  // A zero divisor yields zero parts and no overflow
  `CFA_ASSERT_SAME(a_dz_zero, out_valid && out_divide_by_zero, out_c_real == 32'd0 && out_c_imag == 32'd0 && !out_overflow, "bad zero-divisor result")

  // The divide-by-zero flag comes only from a divide by zero
  `CFA_ASSERT_SAME(a_dz_cause, out_valid && out_divide_by_zero, $past(op_t'(in_op) == OP_DIV && in_b_real == 32'd0 && in_b_imag == 32'd0, LAT), "flag without zero divisor")

  // The block never holds off the sender
  `CFA_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind complex_fixed_point_alu_top cfa_checker u_cfa_checker (.*);

// ===== tb/complex_fixed_point_alu_top_tb.sv =====
`timescale 1ns / 1ps

module complex_fixed_point_alu_top_tb;
  import cfa_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned N_RANDOM = 1330;

  typedef struct {
    logic [31:0] c_real;
    logic [31:0] c_imag;
    logic        dz;
    logic        ovf;
  } cplx_res_t;

  int unsigned n_fail = 0;

  // Print one mismatch line and count it
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    n_fail++;
  endtask

  // Saturate a signed value (sign and magnitude) to 32 bits
  function automatic logic [31:0] clamp(input logic neg, input logic big,
                                        input logic [127:0] q, inout logic ovf);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (big || q > lim) begin
      ovf = 1'b1;
      q = lim;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  // Floor shift of a wide product sum, then saturate
  function automatic logic [31:0] shift_part(input logic signed [127:0] v, inout logic ovf);
    logic neg;
    logic [127:0] mag, q;
    neg = v < 0;
    mag = neg ? -v : v;
    q = neg ? (mag + ((128'd1 << FB) - 1)) >> FB : mag >> FB;
    return clamp(neg, 1'b0, q, ovf);
  endfunction

  // Scaled numerator over |b|^2, truncated toward zero, then saturate
  function automatic logic [31:0] quot_part(input logic signed [127:0] n,
                                            input logic [127:0] z, inout logic ovf);
    logic neg;
    logic [127:0] mag, q;
    neg = n < 0;
    mag = neg ? -n : n;
    q = (mag << FB) / z;
    return clamp(neg, 1'b0, q, ovf);
  endfunction

  function automatic cplx_res_t cplx_compute(input op_t op, input logic [31:0] ar_u,
      input logic [31:0] ai_u, input logic [31:0] br_u, input logic [31:0] bi_u);
    cplx_res_t r;
    logic signed [127:0] ar, ai, br, bi, sr, si, z;
    ar = 128'(signed'(ar_u)); ai = 128'(signed'(ai_u));
    br = 128'(signed'(br_u)); bi = 128'(signed'(bi_u));
    r.ovf = 1'b0; r.dz = 1'b0; r.c_real = '0; r.c_imag = '0;
    case (op)
      OP_ADD, OP_SUB: begin
        sr = (op == OP_ADD) ? ar + br : ar - br;
        si = (op == OP_ADD) ? ai + bi : ai - bi;
        r.c_real = clamp(sr < 0, 1'b0, sr < 0 ? -sr : sr, r.ovf);
        r.c_imag = clamp(si < 0, 1'b0, si < 0 ? -si : si, r.ovf);
      end
      OP_MUL: begin
        r.c_real = shift_part(ar * br - ai * bi, r.ovf);
        r.c_imag = shift_part(ar * bi + ai * br, r.ovf);
      end
      default: begin
        z = br * br + bi * bi;
        if (z == 0) r.dz = 1'b1;
        else begin
          r.c_real = quot_part(ar * br + ai * bi, z, r.ovf);
          r.c_imag = quot_part(ai * br - ar * bi, z, r.ovf);
        end
      end
    endcase
    return r;
  endfunction

  class cplx_scoreboard;
    cplx_res_t pending[$];
    int unsigned n_checked = 0;
    int unsigned n_dz = 0;
    int unsigned n_ovf = 0;

    function void note_input(op_t op, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi);
      pending.push_back(cplx_compute(op, ar, ai, br, bi));
    endfunction

    task check_result(logic [31:0] cr, logic [31:0] ci, logic dz, logic ovf);
      cplx_res_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", cr, 32'd0);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.dz) n_dz++;
      if (e.ovf) n_ovf++;
      if (cr !== e.c_real) report("c_real", cr, e.c_real);
      if (ci !== e.c_imag) report("c_imag", ci, e.c_imag);
      if (dz !== e.dz) report("divide_by_zero", 32'(dz), 32'(e.dz));
      if (ovf !== e.ovf) report("overflow", 32'(ovf), 32'(e.ovf));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [31:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid, out_divide_by_zero, out_overflow;
  logic [31:0] out_c_real, out_c_imag;

  cplx_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned n_sent = 0;

  complex_fixed_point_alu_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_a_real(in_a_real), .in_a_imag(in_a_imag),
    .in_b_real(in_b_real), .in_b_imag(in_b_imag),
    .out_valid(out_valid), .out_c_real(out_c_real), .out_c_imag(out_c_imag),
    .out_divide_by_zero(out_divide_by_zero), .out_overflow(out_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge; watchdog on idle cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_input(op_t'(in_op), in_a_real, in_a_imag, in_b_real, in_b_imag);
        n_sent++;
      end
      if (out_valid)
        sb.check_result(out_c_real, out_c_imag, out_divide_by_zero, out_overflow);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d beats pending", sb.pending.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Drive one beat and hold it until accepted
  task automatic send_beat(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    start <= 1'b1;
    in_op <= op; in_a_real <= ar; in_a_imag <= ai; in_b_real <= br; in_b_imag <= bi;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Pick a part: full random half the time, else extremes, zero or small values
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'(signed'($urandom_range(0, 2**20)) - (2**19));
      4: return 32'(signed'($urandom_range(0, 2**24)) - (2**23));
      default: return $urandom;
    endcase
  endfunction

  // Hold the sender off until every expected result has come
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  logic [31:0] ext[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                          32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001};

  initial begin
    int unsigned burst;
    logic [31:0] br, bi;
    op_t op;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes on every operation, zero divisor, tiny divisor
    for (int o = 0; o < 4; o++) begin
      send_beat(op_t'(o), ext[0], ext[0], ext[0], ext[0]);
      send_beat(op_t'(o), ext[1], ext[1], ext[1], ext[1]);
      send_beat(op_t'(o), ext[0], ext[1], ext[1], ext[0]);
      send_beat(op_t'(o), ext[3], ext[4], ext[5], ext[3]);
    end
    send_beat(OP_DIV, ext[3], ext[4], ext[2], ext[2]);
    send_beat(OP_DIV, ext[2], ext[2], ext[2], ext[2]);
    send_beat(OP_DIV, ext[0], ext[1], ext[5], ext[2]);
    send_beat(OP_DIV, ext[1], ext[1], ext[2], ext[5]);
    send_beat(OP_MUL, ext[4], ext[4], ext[4], ext[4]);
    send_beat(OP_SUB, ext[2], ext[1], ext[2], ext[0]);
    // Let every directed result arrive before the random part
    drain();

    // Random bursts with random gaps
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
        op = op_t'($urandom_range(0, 3));
        br = rand_part(); bi = rand_part();
        if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
          br = '0; bi = '0;
        end
        send_beat(op, rand_part(), rand_part(), br, bi);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 50));
      if (i == N_RANDOM / 2) drain();
    end
    drain();
    repeat (LAT + 10) @(negedge clk);

    $display("checked %0d results (%0d divide-by-zero, %0d saturated) of %0d beats sent",
             sb.n_checked, sb.n_dz, sb.n_ovf, n_sent);
    $display("all four operations covered with extreme, small and random operands");
    if (n_fail == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
